@@ design/dhd_pkg.sv @@
`timescale 1ns / 1ps

package dhd_pkg;

	localparam int NUM_CLASSES = 80;
	localparam int CNT_W       = 7;
	localparam int VAL_W       = 24;
	localparam int CLASS_W     = 8;
	localparam int THR_W       = 13;
	localparam int PAD_W       = 10;
	localparam int ISCALE_W    = 24;
	localparam int CONF_W      = 13;
	localparam int CONF_MAX    = 4096;

	// pixel padding sits at 2^13 in the doubled-coordinate numerator
	localparam int PAD_SHIFT   = 13;
	localparam int NUM_W       = 27;
	localparam int MAG_W       = 26;
	localparam int PROD_W      = MAG_W + ISCALE_W;
	localparam int ROUND_SHIFT = 29;
	localparam int Q_W         = PROD_W - ROUND_SHIFT;

	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic FUNC_BOX   = 1'b0;
	localparam logic FUNC_SCORE = 1'b1;

	typedef enum logic [1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_PAD_LEFT  = 2'd1,
		CFG_PAD_TOP   = 2'd2,
		CFG_INV_SCALE = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                    func;
		logic signed [VAL_W-1:0] value;
		logic                    last;
	} dhd_in_t;

	typedef struct packed {
		logic signed [15:0]        left;
		logic signed [15:0]        top;
		logic [14:0]               box_width;
		logic [14:0]               box_height;
		logic signed [CLASS_W-1:0] class_idx;
		logic [CONF_W-1:0]         confidence;
	} dhd_out_t;

	typedef struct packed {
		logic [THR_W-1:0]    score_threshold;
		logic [PAD_W-1:0]    pad_left;
		logic [PAD_W-1:0]    pad_top;
		logic [ISCALE_W-1:0] inverse_scale;
	} dhd_cfg_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]   cx;
		logic signed [VAL_W-1:0]   cy;
		logic signed [VAL_W-1:0]   w;
		logic signed [VAL_W-1:0]   h;
		logic signed [CLASS_W-1:0] class_idx;
		logic [CONF_W-1:0]         confidence;
	} dhd_job_t;

endpackage

@@ design/dhd_front.sv @@
`timescale 1ns / 1ps

module dhd_front (
	input  logic             clk,
	input  logic             arst_n,
	input  dhd_pkg::dhd_cfg_t cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  dhd_pkg::dhd_in_t in_data,
	input  logic             q_full,
	output logic             push,
	output dhd_pkg::dhd_job_t job
);
	import dhd_pkg::*;

	logic signed [VAL_W-1:0]   box_q [4];
	logic [1:0]                slot_q;
	logic [CNT_W-1:0]          count_q;
	logic signed [VAL_W-1:0]   best_q;
	logic signed [CLASS_W-1:0] class_q;

	logic                      accept;
	logic                      is_score;
	logic                      take;
	logic                      better;
	logic                      col_end;
	logic                      emit;
	logic signed [VAL_W-1:0]   best_nx;
	logic signed [CLASS_W-1:0] class_nx;
	logic signed [VAL_W-1:0]   thr_ext;

	assign in_stall = q_full;
	assign accept   = in_valid & ~q_full;
	assign is_score = (in_data.func == FUNC_SCORE);

	// scores beyond the class count are dropped
	assign take     = (count_q < CNT_W'(NUM_CLASSES));
	assign better   = take && (in_data.value > best_q);
	assign best_nx  = better ? in_data.value : best_q;
	assign class_nx = better ? CLASS_W'(count_q) : class_q;

	assign thr_ext  = $signed({{(VAL_W-THR_W){1'b0}}, cfg.score_threshold});
	assign emit     = (best_nx >= thr_ext);
	assign col_end  = accept & is_score & in_data.last;
	assign push     = col_end & emit;

	always_comb begin
		job.cx        = box_q[0];
		job.cy        = box_q[1];
		job.w         = box_q[2];
		job.h         = box_q[3];
		job.class_idx = class_nx;
		// best never goes negative, so only the top needs a clamp
		if (best_nx > VAL_W'(CONF_MAX)) begin
			job.confidence = CONF_W'(CONF_MAX);
		end else begin
			job.confidence = best_nx[CONF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				box_q[i] <= '0;
			end
			slot_q  <= '0;
			count_q <= '0;
			best_q  <= '0;
			class_q <= '1;
		end else if (accept) begin
			if (!is_score) begin
				box_q[slot_q] <= in_data.value;
				slot_q        <= slot_q + 2'd1;
			end else if (in_data.last) begin
				slot_q  <= '0;
				count_q <= '0;
				best_q  <= '0;
				class_q <= '1;
			end else if (take) begin
				best_q  <= best_nx;
				class_q <= class_nx;
				count_q <= count_q + CNT_W'(1);
			end
		end
	end

	a_col_clear: assert property (@(posedge clk) disable iff (!arst_n)
		col_end |=> (count_q == '0) && (best_q == '0) && (slot_q == '0) && (class_q == '1))
		else $error("column state not cleared after last score");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_CLASSES))
		else $error("score count past class count");

endmodule

@@ design/dhd_queue.sv @@
`timescale 1ns / 1ps

module dhd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dhd_pkg::dhd_job_t job_in,
	input  logic              pop,
	output dhd_pkg::dhd_job_t job_out,
	output logic              empty,
	output logic              full
);
	import dhd_pkg::*;

	dhd_job_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == QCNT_W'(QDEPTH));
	assign job_out = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full) && !(pop && empty))
		else $error("detection queue overflow or underflow");

endmodule

@@ design/dhd_back.sv @@
`timescale 1ns / 1ps

module dhd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dhd_pkg::dhd_cfg_t cfg,
	input  logic              q_valid,
	input  dhd_pkg::dhd_job_t q_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output dhd_pkg::dhd_out_t out_data
);
	import dhd_pkg::*;

	function automatic logic [MAG_W-1:0] abs_mag(input logic signed [NUM_W-1:0] v);
		logic signed [NUM_W-1:0] a;
		a = v[NUM_W-1] ? -v : v;
		return a[MAG_W-1:0];
	endfunction

	function automatic logic signed [15:0] sat_s16(input logic signed [Q_W:0] v);
		logic signed [15:0] r;
		if (v > (Q_W+1)'(32767)) begin
			r = 16'sd32767;
		end else if (v < -(Q_W+1)'(32768)) begin
			r = -16'sd32768;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	function automatic logic [14:0] sat_u15(input logic signed [Q_W:0] v);
		logic [14:0] r;
		if (v[Q_W]) begin
			r = '0;
		end else if (v > (Q_W+1)'(32767)) begin
			r = 15'h7fff;
		end else begin
			r = v[14:0];
		end
		return r;
	endfunction

	logic                      adv;
	logic signed [NUM_W-1:0]   num [4];

	logic                      v_s1;
	logic [MAG_W-1:0]          mag_s1 [4];
	logic [3:0]                neg_s1;
	logic signed [CLASS_W-1:0] class_s1;
	logic [CONF_W-1:0]         conf_s1;

	logic                      v_s2;
	logic [PROD_W-1:0]         prod_s2 [4];
	logic [3:0]                neg_s2;
	logic signed [CLASS_W-1:0] class_s2;
	logic [CONF_W-1:0]         conf_s2;

	logic signed [Q_W:0]       res [4];
	logic                      out_valid_q;
	dhd_out_t                  out_data_q;

	// whole pipe holds while the output beat waits
	assign adv = ~(out_valid_q & out_stall);
	assign pop = adv & q_valid;

	// doubled-coordinate numerators: 2*cx - w - pad, 2*cy - h - pad, 2*w, 2*h
	always_comb begin
		num[0] = (NUM_W'(q_job.cx) <<< 1) - NUM_W'(q_job.w)
			- $signed({{(NUM_W-PAD_W-PAD_SHIFT){1'b0}}, cfg.pad_left, {PAD_SHIFT{1'b0}}});
		num[1] = (NUM_W'(q_job.cy) <<< 1) - NUM_W'(q_job.h)
			- $signed({{(NUM_W-PAD_W-PAD_SHIFT){1'b0}}, cfg.pad_top, {PAD_SHIFT{1'b0}}});
		num[2] = NUM_W'(q_job.w) <<< 1;
		num[3] = NUM_W'(q_job.h) <<< 1;
	end

	// round half away from zero on the magnitude, then restore sign
	always_comb begin
		logic [PROD_W-1:0] rnd;
		logic [Q_W-1:0]    q;
		for (int i = 0; i < 4; i++) begin
			rnd    = prod_s2[i] + (PROD_W'(1) << (ROUND_SHIFT - 1));
			q      = rnd[ROUND_SHIFT +: Q_W];
			res[i] = neg_s2[i] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				mag_s1[i]  <= abs_mag(num[i]);
				neg_s1[i]  <= num[i][NUM_W-1];
				prod_s2[i] <= PROD_W'(mag_s1[i]) * PROD_W'(cfg.inverse_scale);
			end
			class_s1 <= q_job.class_idx;
			conf_s1  <= q_job.confidence;
			neg_s2   <= neg_s1;
			class_s2 <= class_s1;
			conf_s2  <= conf_s1;

			out_data_q.left       <= sat_s16(res[0]);
			out_data_q.top        <= sat_s16(res[1]);
			out_data_q.box_width  <= sat_u15(res[2]);
			out_data_q.box_height <= sat_u15(res[3]);
			out_data_q.class_idx  <= class_s2;
			out_data_q.confidence <= conf_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= q_valid;
			v_s2        <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_pop_enters: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped detection did not enter the pipe");

	a_s2_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && adv) |=> out_valid_q)
		else $error("detection lost between multiply and output");

endmodule

@@ design/detection_head_decode_unit.sv @@
`timescale 1ns / 1ps

// channel | signals                                   | beat
// in      | in_valid, in_stall, in_data (dhd_in_t)    | one box value or class score
// out     | out_valid, out_stall, out_data (dhd_out_t)| one detection
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// Takes one input beat per cycle while in_stall is low; column state is updated in the cycle of the beat.
// After its last score is taken, a detection passes the queue, stage 1, stage 2 and the output register.
// Up to four detections wait between the front and the output pipe; in_stall rises only
// when that queue is full. out_stall holds the three-stage output pipe as a whole.
// Reset clears column state, box values and the registers to their defaults; cfg_ready is
// always high.

module detection_head_decode_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  dhd_pkg::dhd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output dhd_pkg::dhd_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data
);
	import dhd_pkg::*;

	dhd_cfg_t cfg_q;
	dhd_job_t front_job;
	dhd_job_t q_job;
	logic     push;
	logic     pop;
	logic     q_empty;
	logic     q_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.score_threshold <= THR_W'(1024);
			cfg_q.pad_left        <= '0;
			cfg_q.pad_top         <= '0;
			cfg_q.inverse_scale   <= ISCALE_W'(65536);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_THRESHOLD: cfg_q.score_threshold <= cfg_data[THR_W-1:0];
				CFG_PAD_LEFT:  cfg_q.pad_left        <= cfg_data[PAD_W-1:0];
				CFG_PAD_TOP:   cfg_q.pad_top         <= cfg_data[PAD_W-1:0];
				CFG_INV_SCALE: cfg_q.inverse_scale   <= cfg_data[ISCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dhd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.job      (front_job)
	);

	dhd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.job_in  (front_job),
		.pop     (pop),
		.job_out (q_job),
		.empty   (q_empty),
		.full    (q_full)
	);

	dhd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (~q_empty),
		.q_job     (q_job),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
